>>> rtl/burner_short_cycle_guard_assert.svh
`ifndef BURNER_SHORT_CYCLE_GUARD_ASSERT_SVH
`define BURNER_SHORT_CYCLE_GUARD_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSCG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bscg: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bscg: next-cycle check failed");

`endif

>>> rtl/bscg_pkg.sv
package bscg_pkg;

	// Width of the stored timestamps; elapsed times wrap at this width.
	localparam int TIME_BITS = 32;
	// Width at which elapsed times are compared against the 32-bit limits.
	localparam int CMP_W     = (TIME_BITS > 32) ? TIME_BITS : 32;

	localparam int MS_W      = 32;
	localparam int LEVEL_W   = 2;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 2;

	typedef logic [TIME_BITS-1:0] stamp_t;
	typedef logic [MS_W-1:0]      ms_t;
	typedef logic [LEVEL_W-1:0]   level_t;

	localparam level_t LVL_OFF  = 2'd0;
	localparam level_t LVL_LOW  = 2'd1;
	localparam level_t LVL_HIGH = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_CHECK      = 3'd0,
		OP_RESERVE    = 3'd1,
		OP_COMMIT     = 3'd2,
		OP_ROLLBACK   = 3'd3,
		OP_REC_LEVEL  = 3'd4,
		OP_BURNER_ON  = 3'd5,
		OP_BURNER_OFF = 3'd6,
		OP_SOFT_RESET = 3'd7
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_ON     = 2'd0,
		REG_MIN_OFF    = 2'd1,
		REG_MIN_CHANGE = 2'd2,
		REG_NONE       = 2'd3
	} reg_idx_t;

endpackage

>>> rtl/bscg_if.sv
interface bscg_event_if import bscg_pkg::*; ();
	logic   valid;
	logic   ready;
	op_t    operation;
	level_t requested_level;
	ms_t    now_ms;

	modport source (output valid, operation, requested_level, now_ms, input ready);
	modport sink   (input valid, operation, requested_level, now_ms, output ready);
endinterface

interface bscg_result_if import bscg_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   allowed;
	ms_t    wait_until_on;
	ms_t    wait_until_off;
	ms_t    wait_until_change;
	level_t present_level;
	logic   burner_running;
	logic   reservation_open;
	level_t held_level;

	modport source (output valid, allowed, wait_until_on, wait_until_off, wait_until_change,
		present_level, burner_running, reservation_open, held_level, input ready);
	modport sink   (input valid, allowed, wait_until_on, wait_until_off, wait_until_change,
		present_level, burner_running, reservation_open, held_level, output ready);
endinterface

interface bscg_cfg_if import bscg_pkg::*; ();
	logic     valid;
	logic     ready;
	reg_idx_t index;
	ms_t      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/burner_short_cycle_guard.sv
// Channel   Dir  Payload                                          Handshake
// events    in   operation, requested_level, now_ms               valid/ready
// results   out  allowed, wait_until_on/off/change, present_level, valid/ready
//                burner_running, reservation_open, held_level
// cfg       in   index, data (min_on / min_off / min_change ms)   valid/ready
//
// One item per cycle sustained while results are taken; an accepted item passes
// through the input register, elapsed-time stage and output register to result valid.
// The guard state is updated when an item leaves the input register, so back
// to back items see each other's effect with no gap.
// arst_n clears all valid bits and state; limits return to 120000/20000/60000
// ms and the start waiver is set. cfg is always ready.
// Stalls on results back up through the three stages; each stage takes a new
// item whenever it is empty or its item moves on in the same cycle.
module burner_short_cycle_guard import bscg_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	bscg_event_if.sink   events,
	bscg_result_if.source results,
	bscg_cfg_if.sink     cfg
);

	// ---------------- configuration ----------------
	ms_t min_on_q, min_off_q, min_change_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_on_q     <= 32'd120000;
			min_off_q    <= 32'd20000;
			min_change_q <= 32'd60000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MIN_ON:     min_on_q     <= cfg.data;
				REG_MIN_OFF:    min_off_q    <= cfg.data;
				REG_MIN_CHANGE: min_change_q <= cfg.data;
				default:        ; // no register at this index
			endcase
		end
	end

	// ---------------- stage flow control ----------------
	logic v1_q, v2_q, vo_q;
	logic adv_o, adv_2, adv_1;

	assign adv_o = !vo_q || results.ready;
	assign adv_2 = !v2_q || adv_o;
	assign adv_1 = !v1_q || adv_2;

	assign events.ready = adv_1;

	// move1: item in the input register is processed and updates state
	logic move1, move2;
	assign move1 = v1_q && adv_2;
	assign move2 = v2_q && adv_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (adv_1) v1_q <= events.valid;
			if (adv_2) v2_q <= v1_q;
			if (adv_o) vo_q <= v2_q;
		end
	end

	// ---------------- stage 1: input register ----------------
	op_t    op_s1;
	level_t req_raw_s1;
	stamp_t now_s1;

	always_ff @(posedge clk) begin
		if (events.valid && adv_1) begin
			op_s1      <= events.operation;
			req_raw_s1 <= events.requested_level;
			now_s1     <= TIME_BITS'(events.now_ms);
		end
	end

	// ---------------- guard state ----------------
	logic   running_q, pend_q, waiver_q;
	level_t level_q, plev_q;
	stamp_t on_stamp_q, off_stamp_q, chg_stamp_q;

	logic   running_n, pend_n, waiver_n;
	level_t level_n, plev_n;
	stamp_t on_stamp_n, off_stamp_n, chg_stamp_n;

	// level 3 means nothing; treated as high
	level_t req;
	assign req = (req_raw_s1 == 2'd3) ? LVL_HIGH : req_raw_s1;

	// elapsed times against the current state, for the permission decision
	stamp_t since_on, since_off, since_chg;
	logic   on_met, off_met, chg_met;

	assign since_on  = now_s1 - on_stamp_q;
	assign since_off = now_s1 - off_stamp_q;
	assign since_chg = now_s1 - chg_stamp_q;

	assign on_met  = CMP_W'(since_on) >= CMP_W'(min_on_q);
	assign off_met = waiver_q || (CMP_W'(since_off) >= CMP_W'(min_off_q));
	assign chg_met = CMP_W'(since_chg) >= CMP_W'(min_change_q);

	// permission for req, and whether a granted change needs a hold
	logic judge_ok, judge_opens;

	always_comb begin
		judge_ok    = 1'b1;
		judge_opens = 1'b0;
		if (level_q == req) begin
			judge_ok = 1'b1;
		end else if (req == LVL_OFF) begin
			judge_opens = running_q;
			judge_ok    = !running_q || on_met;
		end else begin
			judge_opens = 1'b1;
			if (level_q == LVL_OFF) begin
				judge_ok = running_q || off_met;
			end else begin
				judge_ok = chg_met;
			end
		end
	end

	logic allowed_n;

	always_comb begin
		running_n   = running_q;
		level_n     = level_q;
		pend_n      = pend_q;
		plev_n      = plev_q;
		on_stamp_n  = on_stamp_q;
		off_stamp_n = off_stamp_q;
		chg_stamp_n = chg_stamp_q;
		waiver_n    = waiver_q;
		allowed_n   = 1'b0;
		unique case (op_s1)
			OP_CHECK: begin
				allowed_n = judge_ok;
			end
			OP_RESERVE: begin
				// a second reserve while one is open is denied
				if (!pend_q) begin
					allowed_n = judge_ok;
					if (judge_ok && judge_opens) begin
						pend_n = 1'b1;
						plev_n = req;
					end
				end
			end
			OP_COMMIT: begin
				pend_n = 1'b0;
			end
			OP_ROLLBACK: begin
				if (pend_q) begin
					pend_n = 1'b0;
					plev_n = level_q;
				end
			end
			OP_REC_LEVEL: begin
				if (level_q != req) begin
					level_n     = req;
					chg_stamp_n = now_s1;
					if (req == LVL_OFF) begin
						if (running_q) begin
							running_n   = 1'b0;
							off_stamp_n = now_s1;
						end
					end else if (level_q == LVL_OFF && !running_q) begin
						running_n  = 1'b1;
						on_stamp_n = now_s1;
						waiver_n   = 1'b0;
					end
				end
			end
			OP_BURNER_ON: begin
				if (!running_q) begin
					running_n  = 1'b1;
					on_stamp_n = now_s1;
					waiver_n   = 1'b0;
				end
			end
			OP_BURNER_OFF: begin
				if (running_q) begin
					running_n   = 1'b0;
					off_stamp_n = now_s1;
					level_n     = LVL_OFF;
				end
			end
			OP_SOFT_RESET: begin
				// full minimum off time from now, no waiver
				running_n   = 1'b0;
				level_n     = LVL_OFF;
				pend_n      = 1'b0;
				plev_n      = LVL_OFF;
				on_stamp_n  = '0;
				off_stamp_n = now_s1;
				chg_stamp_n = '0;
				waiver_n    = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			level_q     <= LVL_OFF;
			pend_q      <= 1'b0;
			plev_q      <= LVL_OFF;
			on_stamp_q  <= '0;
			off_stamp_q <= '0;
			chg_stamp_q <= '0;
			waiver_q    <= 1'b1;
		end else if (move1) begin
			running_q   <= running_n;
			level_q     <= level_n;
			pend_q      <= pend_n;
			plev_q      <= plev_n;
			on_stamp_q  <= on_stamp_n;
			off_stamp_q <= off_stamp_n;
			chg_stamp_q <= chg_stamp_n;
			waiver_q    <= waiver_n;
		end
	end

	// ---------------- stage 2: elapsed times after the update ----------------
	stamp_t el_on_s2, el_off_s2, el_chg_s2;
	logic   allowed_s2, running_s2, waiver_s2, pend_s2;
	level_t level_s2, plev_s2;

	always_ff @(posedge clk) begin
		if (move1) begin
			el_on_s2   <= now_s1 - on_stamp_n;
			el_off_s2  <= now_s1 - off_stamp_n;
			el_chg_s2  <= now_s1 - chg_stamp_n;
			allowed_s2 <= allowed_n;
			running_s2 <= running_n;
			waiver_s2  <= waiver_n;
			pend_s2    <= pend_n;
			level_s2   <= level_n;
			plev_s2    <= plev_n;
		end
	end

	// remaining = limit - elapsed, clamped at zero via the borrow bit
	logic [CMP_W:0] d_on, d_off, d_chg;
	ms_t            w_on, w_off, w_chg;

	assign d_on  = {1'b0, CMP_W'(min_off_q)}    - {1'b0, CMP_W'(el_off_s2)};
	assign d_off = {1'b0, CMP_W'(min_on_q)}     - {1'b0, CMP_W'(el_on_s2)};
	assign d_chg = {1'b0, CMP_W'(min_change_q)} - {1'b0, CMP_W'(el_chg_s2)};

	// wait to turn on counts the off time; to turn off, the on time
	assign w_on  = (running_s2 || waiver_s2 || d_on[CMP_W]) ? '0 : d_on[MS_W-1:0];
	assign w_off = (!running_s2 || d_off[CMP_W]) ? '0 : d_off[MS_W-1:0];
	assign w_chg = d_chg[CMP_W] ? '0 : d_chg[MS_W-1:0];

	// ---------------- output register ----------------
	logic   allowed_q, running_o_q, pend_o_q;
	ms_t    w_on_q, w_off_q, w_chg_q;
	level_t level_o_q, plev_o_q;

	always_ff @(posedge clk) begin
		if (move2) begin
			allowed_q   <= allowed_s2;
			w_on_q      <= w_on;
			w_off_q     <= w_off;
			w_chg_q     <= w_chg;
			level_o_q   <= level_s2;
			running_o_q <= running_s2;
			pend_o_q    <= pend_s2;
			plev_o_q    <= plev_s2;
		end
	end

	assign results.valid             = vo_q;
	assign results.allowed           = allowed_q;
	assign results.wait_until_on     = w_on_q;
	assign results.wait_until_off    = w_off_q;
	assign results.wait_until_change = w_chg_q;
	assign results.present_level     = level_o_q;
	assign results.burner_running    = running_o_q;
	assign results.reservation_open  = pend_o_q;
	assign results.held_level        = plev_o_q;

	// ---------------- assertions ----------------
`include "burner_short_cycle_guard_assert.svh"

	// once cleared, the start waiver only comes back with a hardware reset
	`BSCG_ASSERT_NEXT(a_waiver_stays_clear, clk, arst_n, !waiver_q, !waiver_q)
	// any level above off implies the burner is recorded as running
	`BSCG_ASSERT_NOW(a_level_implies_running, clk, arst_n, level_q != LVL_OFF, running_q)
	// an item processed in stage 1 is never dropped before stage 2
	`BSCG_ASSERT_NEXT(a_stage1_to_stage2, clk, arst_n, move1, v2_q)

endmodule
